@@ rtl/core/pcmfc_pkg.sv @@
package pcmfc_pkg;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S32 = 2'd2,
    FMT_F32 = 2'd3
  } fmt_e;

  localparam logic CFG_IDX_IN  = 1'b0;
  localparam logic CFG_IDX_OUT = 1'b1;

  typedef struct packed {
    logic        ok;
    logic [31:0] sample;
    logic        last;
  } conv_res_t;

  // Signed 16-bit value scaled by 2^-15, exact in single precision.
  function automatic logic [31:0] pcm16_to_float(input logic [15:0] s);
    logic        sgn;
    logic [15:0] mag;
    logic [4:0]  msb;
    logic [22:0] man;
    logic [7:0]  ex;
    sgn = s[15];
    mag = sgn ? (~s + 16'd1) : s;
    msb = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    man = 23'({7'd0, mag} << (5'd23 - msb));
    ex  = 8'(8'd112 + {3'd0, msb});
    if (mag == 16'd0) begin
      pcm16_to_float = 32'd0;
    end else begin
      pcm16_to_float = {sgn, ex, man};
    end
  endfunction

  // Single float times 2^15, truncated toward zero, clamped to S16; NaN gives 0.
  function automatic logic [15:0] float_to_pcm16(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] sig;
    logic [15:0] mag;
    logic        big;
    sgn = f[31];
    ex  = f[30:23];
    sig = {1'b1, f[22:0]};
    big = 1'b0;
    mag = 16'd0;
    // value*2^15 = sig * 2^(ex-150+15); integer part = sig >> (135-ex)
    if (ex == 8'hFF && f[22:0] != 23'd0) begin
      mag = 16'd0;
    end else if (ex >= 8'd127) begin
      big = 1'b1;
    end else if (ex >= 8'd112) begin
      mag = 16'(sig >> (8'd135 - ex));
    end
    if (ex == 8'hFF && f[22:0] != 23'd0) begin
      float_to_pcm16 = 16'd0;
    end else if (big) begin
      float_to_pcm16 = sgn ? 16'h8000 : 16'h7FFF;
    end else begin
      float_to_pcm16 = sgn ? (~mag + 16'd1) : mag;
    end
  endfunction

endpackage

@@ rtl/core/pcmfc_conv.sv @@
module pcmfc_conv (
  input  pcmfc_pkg::fmt_e      fmt_in_i,
  input  pcmfc_pkg::fmt_e      fmt_out_i,
  input  logic [31:0]          sample_i,
  input  logic                 last_i,
  output pcmfc_pkg::conv_res_t res_o
);

  always_comb begin
    res_o.ok     = 1'b1;
    res_o.last   = last_i;
    res_o.sample = 32'd0;
    if (fmt_in_i == pcmfc_pkg::FMT_S16 && fmt_out_i == pcmfc_pkg::FMT_S32) begin
      res_o.sample = {sample_i[15:0], 16'd0};
    end else if (fmt_in_i == pcmfc_pkg::FMT_S32 && fmt_out_i == pcmfc_pkg::FMT_S16) begin
      res_o.sample = {16'd0, sample_i[31:16]};
    end else if (fmt_in_i == pcmfc_pkg::FMT_S16 && fmt_out_i == pcmfc_pkg::FMT_F32) begin
      res_o.sample = pcmfc_pkg::pcm16_to_float(sample_i[15:0]);
    end else if (fmt_in_i == pcmfc_pkg::FMT_F32 && fmt_out_i == pcmfc_pkg::FMT_S16) begin
      res_o.sample = {16'd0, pcmfc_pkg::float_to_pcm16(sample_i)};
    end else if (fmt_in_i == pcmfc_pkg::FMT_S32 && fmt_out_i == pcmfc_pkg::FMT_F32) begin
      res_o.sample = pcmfc_pkg::pcm16_to_float(sample_i[31:16]);
    end else if (fmt_in_i == pcmfc_pkg::FMT_F32 && fmt_out_i == pcmfc_pkg::FMT_S32) begin
      res_o.sample = {pcmfc_pkg::float_to_pcm16(sample_i), 16'd0};
    end else if (fmt_in_i == pcmfc_pkg::FMT_U8 && fmt_out_i == pcmfc_pkg::FMT_S16) begin
      res_o.sample = {16'd0, ~sample_i[7], sample_i[6:0], 8'd0};
    end else if (fmt_in_i == pcmfc_pkg::FMT_S16 && fmt_out_i == pcmfc_pkg::FMT_U8) begin
      res_o.sample = {24'd0, ~sample_i[15], sample_i[14:8]};
    end else begin
      res_o.ok = 1'b0;
    end
  end

endmodule

@@ rtl/core/pcm_sample_format_converter.sv @@
// PCM sample format converter.
// Slave stream (s_axis_*): one raw sample per request, tdata = sample_in,
// tlast = end of buffer. Master stream (m_axis_*): tdata = converted sample,
// tlast copied from the input.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 = input format, 1 = output format; 0=U8 1=S16 2=S32 3=F32).
// Write config only while the block is idle.
// A request taken from s_axis waits in the input register, passes the
// converter into the output register and is presented on m_axis from there.
// Throughput: one sample per cycle while m_axis does not stall, set by the
// two-register pipe (input register, output register).
// Unsupported format pairs swallow the sample: nothing comes out.
// Reset: both formats return to S16, pipe empties.
// Receiver stall: the output register holds; the input register keeps its
// sample and tready drops only when both registers are full and stalled.
module pcm_sample_format_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sample_out
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i
);

  pcmfc_pkg::fmt_e fmt_in_q, fmt_out_q;

  logic        in_vld_q;
  logic [31:0] in_data_q;
  logic        in_last_q;
  logic        out_vld_q;
  logic [31:0] out_data_q;
  logic        out_last_q;

  pcmfc_pkg::conv_res_t res;
  logic out_free, in_move;

  pcmfc_conv u_conv (
    .fmt_in_i  (fmt_in_q),
    .fmt_out_i (fmt_out_q),
    .sample_i  (in_data_q),
    .last_i    (in_last_q),
    .res_o     (res)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_move       = in_vld_q && (out_free || !res.ok);
  assign s_axis_tready = !in_vld_q || in_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_in_q  <= pcmfc_pkg::FMT_S16;
      fmt_out_q <= pcmfc_pkg::FMT_S16;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pcmfc_pkg::CFG_IDX_IN) fmt_in_q <= pcmfc_pkg::fmt_e'(cfg_data_i);
        else fmt_out_q <= pcmfc_pkg::fmt_e'(cfg_data_i);
      end
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_free) out_vld_q <= in_move && res.ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (out_free && in_move) begin
      out_data_q <= res.sample;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/pcmfc_checker.sv @@
module pcmfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast)) else $error("stalled output changed");

  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("valid after reset");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready) else $error("ready lost while draining");

endmodule

bind pcm_sample_format_converter pcmfc_checker u_pcmfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ test/pcm_sample_format_converter_tb.sv @@
module pcm_sample_format_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One stream request: raw sample plus end-of-buffer marker
  typedef struct {
    logic [31:0] sample;
    logic        last;
  } pcm_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] sample_in
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] sample_out
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [1:0]  cfg_data_i = '0;

  pcm_sample_format_converter dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pcm_req_t        pending_q[$];      // requests still to be sent
  pcm_req_t        converted_q[$];    // expected converted samples, oldest first
  pcmfc_pkg::fmt_e fmt_in  = pcmfc_pkg::FMT_S16; // shadow copies of the format regs
  pcmfc_pkg::fmt_e fmt_out = pcmfc_pkg::FMT_S16;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  bit              send_hold = 1'b0;
  int              errors = 0;
  int              n_sent = 0;
  int              n_checked = 0;
  int              n_swallowed = 0;

  // S16 code scaled by 2^-15 as single-precision bits (always exact)
  function automatic logic [31:0] pcm16_as_float(logic [15:0] code);
    logic [15:0] mag;
    int          top;
    mag = code[15] ? 16'(-code) : code;
    if (mag == 16'd0) return 32'd0;
    top = 15;
    while (!mag[top]) top--;
    return {code[15], 8'(112 + top), 23'({7'd0, mag} << (23 - top))};
  endfunction

  // Float times 2^15, truncated toward zero, saturated to S16; NaN is zero
  function automatic logic [15:0] float_as_pcm16(logic [31:0] f);
    logic [7:0]  e;
    logic [23:0] sig;
    logic [15:0] mag;
    e   = f[30:23];
    sig = {1'b1, f[22:0]};
    if (e == 8'hFF && f[22:0] != '0) return 16'd0;
    if (e >= 8'd127) return f[31] ? 16'h8000 : 16'h7FFF;
    mag = (e >= 8'd112) ? 16'(sig >> (135 - e)) : 16'd0;
    return f[31] ? 16'(-mag) : mag;
  endfunction

  // Converted sample for the current format pair; ok low when pair unsupported
  function automatic bit convert_sample(logic [31:0] x, output logic [31:0] r);
    r = '0;
    case ({fmt_in, fmt_out})
      {pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_S32}: r = {x[15:0], 16'd0};
      {pcmfc_pkg::FMT_S32, pcmfc_pkg::FMT_S16}: r = {16'd0, x[31:16]};
      {pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_F32}: r = pcm16_as_float(x[15:0]);
      {pcmfc_pkg::FMT_F32, pcmfc_pkg::FMT_S16}: r = {16'd0, float_as_pcm16(x)};
      {pcmfc_pkg::FMT_S32, pcmfc_pkg::FMT_F32}: r = pcm16_as_float(x[31:16]);
      {pcmfc_pkg::FMT_F32, pcmfc_pkg::FMT_S32}: r = {float_as_pcm16(x), 16'd0};
      {pcmfc_pkg::FMT_U8,  pcmfc_pkg::FMT_S16}: r = {16'd0, x[7:0] ^ 8'h80, 8'd0};
      {pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_U8}:  r = {24'd0, x[15:8] ^ 8'h80};
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (in %s out %s) at %0t",
             what, got, want, fmt_in.name(), fmt_out.name(), $realtime);
    errors++;
  endtask

  // Driver: a request leaves at each edge with valid and ready high; the
  // expectation is derived right there from the registers in force
  always @(posedge clk_i or negedge rst_ni) begin
    pcm_req_t    req;
    logic [31:0] r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_sent++;
        if (convert_sample(s_axis_tdata, r)) begin
          req.sample = r;
          req.last   = s_axis_tlast;
          converted_q.push_back(req);
        end else begin
          n_swallowed++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.sample;
          s_axis_tlast  <= req.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure, each accepted result checked in order
  always @(posedge clk_i or negedge rst_ni) begin
    pcm_req_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (converted_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          want = converted_q.pop_front();
          n_checked++;
          if (m_axis_tdata !== want.sample)
            report_mismatch("sample", m_axis_tdata, want.sample);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Waits until every queued request went out and every result came back,
  // then lets the two-stage pipe drain swallowed samples too; sampled
  // mid-cycle so the edge updates have settled
  task automatic wait_idle();
    while (pending_q.size() != 0 || s_axis_tvalid || converted_q.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_formats(pcmfc_pkg::fmt_e fi, pcmfc_pkg::fmt_e fo);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pcmfc_pkg::CFG_IDX_IN;
    cfg_data_i <= fi;
    @(posedge clk_i);
    cfg_idx_i  <= pcmfc_pkg::CFG_IDX_OUT;
    cfg_data_i <= fo;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    fmt_in  = fi;
    fmt_out = fo;
  endtask

  task automatic queue_sample(logic [31:0] s);
    pcm_req_t req;
    req.sample = s;
    req.last   = 1'($urandom_range(1));
    pending_q.push_back(req);
  endtask

  // Random sample shaped for the input format: fully random bits, floats
  // near the interesting range, or format extremes
  function automatic logic [31:0] rand_sample();
    logic [31:0] corner[10] = '{32'h0, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                                32'h7FC0_0000, 32'h8000_0000, 32'h0000_8000,
                                32'h7FFF_7FFF, 32'h3800_0000, 32'hBF80_0000};
    case ($urandom_range(3))
      0: return corner[$urandom_range(9)];
      1: if (fmt_in == pcmfc_pkg::FMT_F32)
           return {1'($urandom_range(1)), 8'($urandom_range(130, 105)),
                   23'($urandom)};
         else return $urandom;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] directed[14] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h3F80_0000,
                                  32'hBF80_0000, 32'h3F00_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0001,
                                  32'h3800_0000, 32'h37FF_FFFF, 32'h8000_0000,
                                  32'h0000_8000, 32'h8000_7F80};
    pcmfc_pkg::fmt_e fi, fo;
    int              n;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset formats (S16 to itself swallows), then float to S16
    // with the full set of float and integer corners, then one sample per pair
    queue_sample(32'h0000_7FFF);
    wait_idle();
    write_formats(pcmfc_pkg::FMT_F32, pcmfc_pkg::FMT_S16);
    foreach (directed[i]) queue_sample(directed[i]);
    wait_idle();
    for (int p = 0; p < 16; p++) begin
      write_formats(pcmfc_pkg::fmt_e'(p / 4), pcmfc_pkg::fmt_e'(p % 4));
      queue_sample(directed[p % 2]);
      wait_idle();
    end

    // Random phases; idling mode rotates, the first ones hit the extremes
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph < 4) begin
        fi = (ph < 2) ? pcmfc_pkg::FMT_F32 : pcmfc_pkg::FMT_U8;
        fo = (ph == 0) ? pcmfc_pkg::FMT_S32 : pcmfc_pkg::FMT_S16;
        if (ph == 3) begin fi = pcmfc_pkg::FMT_S16; fo = pcmfc_pkg::FMT_U8; end
      end else if ($urandom_range(9) < 8) begin
        // mostly supported pairs
        case ($urandom_range(7))
          0: begin fi = pcmfc_pkg::FMT_S16; fo = pcmfc_pkg::FMT_S32; end
          1: begin fi = pcmfc_pkg::FMT_S32; fo = pcmfc_pkg::FMT_S16; end
          2: begin fi = pcmfc_pkg::FMT_S16; fo = pcmfc_pkg::FMT_F32; end
          3: begin fi = pcmfc_pkg::FMT_F32; fo = pcmfc_pkg::FMT_S16; end
          4: begin fi = pcmfc_pkg::FMT_S32; fo = pcmfc_pkg::FMT_F32; end
          5: begin fi = pcmfc_pkg::FMT_F32; fo = pcmfc_pkg::FMT_S32; end
          6: begin fi = pcmfc_pkg::FMT_U8;  fo = pcmfc_pkg::FMT_S16; end
          default: begin fi = pcmfc_pkg::FMT_S16; fo = pcmfc_pkg::FMT_U8; end
        endcase
      end else begin
        fi = pcmfc_pkg::fmt_e'($urandom_range(3));
        fo = pcmfc_pkg::fmt_e'($urandom_range(3));
      end
      write_formats(fi, fo);
      n = $urandom_range(75, 50);
      for (int k = 0; k < n; k++) queue_sample(rand_sample());
      if (ph == 9) begin
        // let half the phase go out, then hold the sender until the pipe
        // has fully drained
        while (pending_q.size() > n / 2) @(negedge clk_i);
        send_hold = 1'b1;
        while (converted_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
        send_hold = 1'b0;
      end
      wait_idle();
    end

    $display("Sent %0d samples over all 16 format pairs; %0d results checked, %0d swallowed",
             n_sent, n_checked, n_swallowed);
    $display("Covered float corners (NaN, infinities, saturation) and four idling modes");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pcmfc_pkg.sv
rtl/core/pcmfc_conv.sv
rtl/core/pcm_sample_format_converter.sv
rtl/core/pcmfc_checker.sv
test/pcm_sample_format_converter_tb.sv
